>>> rtl/text_console_cursor_engine_defines.svh
// Assertion macros shared by the text console cursor engine RTL.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// A condition that must hold on every clock edge outside reset.
`define TCCE_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant violated");

// An antecedent that must be followed by a consequent in the next cycle.
`define TCCE_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle consequence violated");

`else

`define TCCE_ASSERT_ALWAYS(label, clk, rst, expr)
`define TCCE_ASSERT_NEXT(label, clk, ante, cons)

`endif

`endif

>>> rtl/tcce_pkg.sv
// Shared types and constants of the text console cursor engine.
`default_nettype none

package tcce_pkg;

   // Tab stops and the command budget of one input transaction.
   localparam int TAB_WIDTH   = 4;
   localparam int MAX_RESULTS = 8;
   localparam int REM_WIDTH   = $clog2(TAB_WIDTH + 1);
   localparam int COUNT_WIDTH = $clog2(MAX_RESULTS + 1);

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // Character codes with special meaning.
   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] CODE_TAB     = 8'd9;
   localparam logic [7:0] CODE_SPACE   = 8'd32;

   // Command kinds on the result channel.
   localparam logic CMD_DRAW   = 1'b0;
   localparam logic CMD_SCROLL = 1'b1;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TEXT_COLUMNS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TEXT_ROWS    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TEXT_COLOR   = 2'd2;

   // Configuration reset values.
   localparam logic [7:0]  RESET_TEXT_COLUMNS = 8'd80;
   localparam logic [7:0]  RESET_TEXT_ROWS    = 8'd25;
   localparam logic [31:0] RESET_TEXT_COLOR   = 32'h00FF_FFFF;

   // Class of an input character.
   typedef enum logic [1:0] {
      ITEM_GLYPH,
      ITEM_NEWLINE,
      ITEM_TAB
   } item_kind_type;

   // Classified item as it travels through the queue.
   typedef struct packed {
      item_kind_type kind;
      logic [7:0]    code;
   } item_type;

   // One result command.
   typedef struct packed {
      logic        kind;
      logic [7:0]  column;
      logic [7:0]  row;
      logic [7:0]  glyph;
      logic [31:0] color;
      logic        last;
   } cmd_type;

   // Effective grid configuration seen by the back part.
   typedef struct packed {
      logic [7:0]  columns;
      logic [7:0]  rows;
      logic [31:0] color;
   } cfg_type;

   // Queue status.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

>>> rtl/tcce_front.sv
// Front part: accepts characters and classifies them for the queue.
`default_nettype none

module tcce_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_char_code,
   output logic                   push_valid,
   input  wire logic              push_ready,
   output tcce_pkg::item_type     push_item
);

   logic               valid_ff;
   logic               valid_in;
   tcce_pkg::item_type item_ff;
   tcce_pkg::item_type item_in;
   logic               take;

   // The holding register frees up whenever the queue takes its transaction.
   assign req_ready  = !valid_ff || push_ready;
   assign take       = req_valid && req_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   // Classify the incoming character.
   always_comb begin
      item_in.code = req_char_code;
      if (req_char_code == tcce_pkg::CODE_NEWLINE) begin
         item_in.kind = tcce_pkg::ITEM_NEWLINE;
      end else if (req_char_code == tcce_pkg::CODE_TAB) begin
         item_in.kind = tcce_pkg::ITEM_TAB;
      end else begin
         item_in.kind = tcce_pkg::ITEM_GLYPH;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/tcce_queue.sv
// Short queue of classified items between the front and back parts.
`default_nettype none

module tcce_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push_valid,
   output logic                          push_ready,
   input  wire tcce_pkg::item_type       push_item,
   output logic                          pop_valid,
   input  wire logic                     pop_ready,
   output tcce_pkg::item_type            pop_item,
   output tcce_pkg::queue_status_type    status
);

   tcce_pkg::item_type                    entries [tcce_pkg::QUEUE_DEPTH];
   logic [tcce_pkg::QPTR_WIDTH-1:0]       wr_ptr_ff;
   logic [tcce_pkg::QPTR_WIDTH-1:0]       wr_ptr_in;
   logic [tcce_pkg::QPTR_WIDTH-1:0]       rd_ptr_ff;
   logic [tcce_pkg::QPTR_WIDTH-1:0]       rd_ptr_in;
   logic [tcce_pkg::QCNT_WIDTH-1:0]       count_ff;
   logic [tcce_pkg::QCNT_WIDTH-1:0]       count_in;
   logic                                  do_push;
   logic                                  do_pop;

   localparam logic [tcce_pkg::QPTR_WIDTH-1:0] LAST_PTR =
      tcce_pkg::QPTR_WIDTH'(tcce_pkg::QUEUE_DEPTH - 1);
   localparam logic [tcce_pkg::QCNT_WIDTH-1:0] FULL_COUNT =
      tcce_pkg::QCNT_WIDTH'(tcce_pkg::QUEUE_DEPTH);

   assign status.full  = (count_ff == FULL_COUNT);
   assign status.empty = (count_ff == '0);
   assign push_ready   = !status.full;
   assign pop_valid    = !status.empty;
   assign pop_item     = entries[rd_ptr_ff];
   assign do_push      = push_valid && push_ready;
   assign do_pop       = pop_valid && pop_ready;

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage write.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> rtl/tcce_back.sv
// Back part: sequencer that moves the cursor and issues draw and scroll commands.
`default_nettype none

module tcce_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tcce_pkg::cfg_type    cfg,
   input  wire logic                 pop_valid,
   output logic                      pop_ready,
   input  wire tcce_pkg::item_type   pop_item,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output tcce_pkg::cmd_type         rsp_cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAW,
      ST_SCROLL,
      ST_NEWLINE
   } state_type;

   state_type                          state_ff;
   state_type                          state_in;
   logic [7:0]                         col_ff;
   logic [7:0]                         col_in;
   logic [7:0]                         row_ff;
   logic [7:0]                         row_in;
   logic [7:0]                         glyph_ff;
   logic [7:0]                         glyph_in;
   logic [tcce_pkg::REM_WIDTH-1:0]     rem_ff;
   logic [tcce_pkg::REM_WIDTH-1:0]     rem_in;
   logic [tcce_pkg::COUNT_WIDTH-1:0]   cnt_ff;
   logic [tcce_pkg::COUNT_WIDTH-1:0]   cnt_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   tcce_pkg::cmd_type                  rsp_cmd_ff;
   tcce_pkg::cmd_type                  rsp_cmd_in;

   logic                               can_emit;
   logic [8:0]                         col_inc;
   logic [8:0]                         row_inc;
   logic                               wrap;
   logic                               past_bottom;
   logic [tcce_pkg::REM_WIDTH-1:0]     rem_dec;
   logic [tcce_pkg::COUNT_WIDTH-1:0]   cnt_inc;
   logic                               budget_out;
   logic [tcce_pkg::REM_WIDTH-1:0]     tab_rem;

   localparam logic [tcce_pkg::COUNT_WIDTH-1:0] BUDGET_LIMIT =
      tcce_pkg::COUNT_WIDTH'(tcce_pkg::MAX_RESULTS - 2);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cmd   = rsp_cmd_ff;
   assign can_emit  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == ST_IDLE);

   // Cursor advance arithmetic; nine bits so a column or row of 255 still compares right.
   assign col_inc     = {1'b0, col_ff} + 9'd1;
   assign row_inc     = {1'b0, row_ff} + 9'd1;
   assign wrap        = (col_inc >= {1'b0, cfg.columns});
   assign past_bottom = (row_inc >= {1'b0, cfg.rows});
   assign rem_dec     = rem_ff - 1'b1;
   assign cnt_inc     = cnt_ff + 1'b1;
   assign budget_out  = (cnt_inc > BUDGET_LIMIT);
   assign tab_rem     = tcce_pkg::REM_WIDTH'(tcce_pkg::TAB_WIDTH)
                      - tcce_pkg::REM_WIDTH'(col_ff % tcce_pkg::TAB_WIDTH);

   // Next-state and command logic.
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      glyph_in     = glyph_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cmd_in   = rsp_cmd_ff;

      case (state_ff)
         ST_IDLE: begin
            // Take the next classified transaction from the queue.
            if (pop_valid) begin
               cnt_in = '0;
               if (pop_item.kind == tcce_pkg::ITEM_NEWLINE) begin
                  state_in = ST_NEWLINE;
               end else if (pop_item.kind == tcce_pkg::ITEM_TAB) begin
                  glyph_in = tcce_pkg::CODE_SPACE;
                  rem_in   = tab_rem;
                  state_in = ST_DRAW;
               end else begin
                  glyph_in = pop_item.code;
                  rem_in   = tcce_pkg::REM_WIDTH'(1);
                  state_in = ST_DRAW;
               end
            end
         end

         ST_DRAW: begin
            // Draw at the cursor, then advance and possibly wrap.
            if (can_emit) begin
               rsp_valid_in      = 1'b1;
               rsp_cmd_in.kind   = tcce_pkg::CMD_DRAW;
               rsp_cmd_in.column = col_ff;
               rsp_cmd_in.row    = row_ff;
               rsp_cmd_in.glyph  = glyph_ff;
               rsp_cmd_in.color  = cfg.color;
               rsp_cmd_in.last   = !(wrap && past_bottom)
                                   && ((rem_dec == '0) || budget_out);
               rem_in = rem_dec;
               cnt_in = cnt_inc;
               if (wrap) begin
                  col_in = '0;
                  row_in = past_bottom ? cfg.rows - 8'd1 : row_inc[7:0];
               end else begin
                  col_in = col_inc[7:0];
               end
               if (wrap && past_bottom) begin
                  state_in = ST_SCROLL;
               end else if (rsp_cmd_in.last) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_SCROLL: begin
            // Scroll after a wrap past the bottom row.
            if (can_emit) begin
               rsp_valid_in      = 1'b1;
               rsp_cmd_in        = '0;
               rsp_cmd_in.kind   = tcce_pkg::CMD_SCROLL;
               rsp_cmd_in.last   = (rem_ff == '0) || budget_out;
               cnt_in            = cnt_inc;
               state_in          = rsp_cmd_in.last ? ST_IDLE : ST_DRAW;
            end
         end

         ST_NEWLINE: begin
            // Newline only yields a command when it scrolls.
            if (!past_bottom) begin
               col_in   = '0;
               row_in   = row_inc[7:0];
               state_in = ST_IDLE;
            end else if (can_emit) begin
               col_in          = '0;
               row_in          = cfg.rows - 8'd1;
               rsp_valid_in    = 1'b1;
               rsp_cmd_in      = '0;
               rsp_cmd_in.kind = tcce_pkg::CMD_SCROLL;
               rsp_cmd_in.last = 1'b1;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, cursor and registered command.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      glyph_ff   <= glyph_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      rsp_cmd_ff <= rsp_cmd_in;
   end

endmodule

`default_nettype wire

>>> rtl/text_console_cursor_engine.sv
// A request is registered in the front holding register and passes the queue; the back
// sequencer dequeues it in its idle state and then registers each command on rsp in its
// draw, scroll or newline state, holding while rsp is not ready, and returns to idle
// before it takes the next item; the front and queue keep it fed back to back.
// Reset: synchronous; the cursor goes to column 0, row 0, the grid to 80 by 25,
// the color to 0xFFFFFF, and the queue and output register empty.
`default_nettype none

`include "text_console_cursor_engine_defines.svh"

module text_console_cursor_engine (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_char_code,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_command_kind,
   output logic [7:0]        rsp_cell_column,
   output logic [7:0]        rsp_cell_row,
   output logic [7:0]        rsp_glyph_code,
   output logic [31:0]       rsp_glyph_color,
   output logic              rsp_last_command,
   input  wire logic         csr_write_en,
   input  wire logic [tcce_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [31:0]  csr_write_data
);

   logic [7:0]                   columns_ff;
   logic [7:0]                   rows_ff;
   logic [31:0]                  color_ff;
   tcce_pkg::cfg_type            cfg;
   logic                         push_valid;
   logic                         push_ready;
   tcce_pkg::item_type           push_item;
   logic                         pop_valid;
   logic                         pop_ready;
   tcce_pkg::item_type           pop_item;
   tcce_pkg::queue_status_type   q_status;
   tcce_pkg::cmd_type            rsp_cmd;
   logic                         scroll_payload_clear;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= tcce_pkg::RESET_TEXT_COLUMNS;
         rows_ff    <= tcce_pkg::RESET_TEXT_ROWS;
         color_ff   <= tcce_pkg::RESET_TEXT_COLOR;
      end else if (csr_write_en) begin
         case (csr_index)
            tcce_pkg::CSR_TEXT_COLUMNS: columns_ff <= csr_write_data[7:0];
            tcce_pkg::CSR_TEXT_ROWS:    rows_ff    <= csr_write_data[7:0];
            tcce_pkg::CSR_TEXT_COLOR:   color_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // A zero grid size behaves as one.
   assign cfg.columns = (columns_ff == 8'd0) ? 8'd1 : columns_ff;
   assign cfg.rows    = (rows_ff == 8'd0) ? 8'd1 : rows_ff;
   assign cfg.color   = color_ff;

   tcce_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_item     (push_item)
   );

   tcce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .status     (q_status)
   );

   tcce_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_cmd   (rsp_cmd)
   );

   assign rsp_command_kind = rsp_cmd.kind;
   assign rsp_cell_column  = rsp_cmd.column;
   assign rsp_cell_row     = rsp_cmd.row;
   assign rsp_glyph_code   = rsp_cmd.glyph;
   assign rsp_glyph_color  = rsp_cmd.color;
   assign rsp_last_command = rsp_cmd.last;

   // A draw may carry anything; a scroll must carry all-zero cell, glyph and color.
   assign scroll_payload_clear = (rsp_command_kind != tcce_pkg::CMD_SCROLL)
                               || ((rsp_cell_column == 8'd0) && (rsp_cell_row == 8'd0)
                                   && (rsp_glyph_code == 8'd0) && (rsp_glyph_color == 32'd0));

   // A scroll command carries no cell, glyph or color.
   `TCCE_ASSERT_ALWAYS(a_scroll_payload_zero, clock, reset, !rsp_valid || scroll_payload_clear)
   // The queue can never look full and empty at once.
   `TCCE_ASSERT_ALWAYS(a_queue_status_sane, clock, reset, !(q_status.full && q_status.empty))
   // Reset leaves no result pending.
   `TCCE_ASSERT_NEXT(a_reset_clears_rsp, clock, reset, !rsp_valid)

endmodule

`default_nettype wire
